### design/gsp_pkg.sv
// Shared types and constants for the gshare branch predictor.
`timescale 1ns / 1ps
package gsp_pkg;

  localparam int HIST_W      = 16;
  localparam int LEN_W       = 5;
  localparam int SHIFT_W     = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;

  localparam logic [2:0] OP_LOOKUP   = 3'd0;
  localparam logic [2:0] OP_UNCOND   = 3'd1;
  localparam logic [2:0] OP_UPDATE   = 3'd2;
  localparam logic [2:0] OP_SQUASH   = 3'd3;
  localparam logic [2:0] OP_BTB_MISS = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_HISTORY_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PC_SHIFT       = 1'd1;

  localparam logic [LEN_W-1:0]   HISTORY_LENGTH_RST = 5'd12;
  localparam logic [SHIFT_W-1:0] PC_SHIFT_RST       = 3'd2;

  typedef struct packed {
    logic [2:0]        operation;
    logic [1:0]        thread;
    logic [31:0]       pc;
    logic              outcome_taken;
    logic              was_squashed;
    logic [HIST_W-1:0] saved_history;
  } req_t;

  typedef struct packed {
    logic              predict_taken;
    logic [HIST_W-1:0] history_snapshot;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load_item;
    logic read_table;
    logic commit;
    logic clear_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic clear_last;
  } ctl_sts_t;

endpackage

### design/gsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gsp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/gsp_ctrl.sv
// Controller state machine: table clearing, item acceptance, read and commit sequencing.
`timescale 1ns / 1ps
module gsp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  gsp_pkg::ctl_sts_t sts,
  output gsp_pkg::ctl_cmd_t ctl
);
  import gsp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_stall  = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          ctl.load_item = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        ctl.read_table = 1'b1;
        state_next     = ST_EXEC;
      end
      ST_EXEC: begin
        // Hold the finished item until the result register can take it.
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  a_load_then_read: assert property (@(posedge clk) disable iff (rst)
    ctl.load_item |=> ctl.read_table)
    else $error("table read did not follow item load");

  a_read_once: assert property (@(posedge clk) disable iff (rst)
    ctl.read_table |=> !ctl.read_table && !ctl.load_item)
    else $error("table read repeated or new item taken during read");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_step && sts.clear_last |=> !ctl.clear_step)
    else $error("clearing pass ran past the last entry");

endmodule

### design/gsp_datapath.sv
// Datapath: config registers, per-thread histories, counter table, index logic, result register.
`timescale 1ns / 1ps
module gsp_datapath #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int COUNTER_BITS  = 2,
  parameter int THREADS       = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gsp_pkg::req_t                       req,
  input  gsp_pkg::ctl_cmd_t                   ctl,
  output gsp_pkg::ctl_sts_t                   sts,
  input  logic                                cfg_we,
  input  logic [gsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gsp_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output gsp_pkg::rsp_t                       rsp
);
  import gsp_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int TID_W = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam logic [HIST_W-1:0]       IDX_MASK = HIST_W'(TABLE_ENTRIES - 1);
  localparam logic [COUNTER_BITS-1:0] CTR_MAX  = {COUNTER_BITS{1'b1}};

  req_t               item;
  logic [LEN_W-1:0]   history_length;
  logic [SHIFT_W-1:0] pc_shift;
  logic [HIST_W-1:0]  history [THREADS];
  logic [IDX_W-1:0]   clr_addr;

  logic [LEN_W-1:0]        len_sat;
  logic [HIST_W-1:0]       hmask;
  logic [TID_W-1:0]        tid;
  logic                    item_ok;
  logic [HIST_W-1:0]       hist_cur;
  logic [HIST_W-1:0]       snap;
  logic [31:0]             pc_shifted;
  logic [HIST_W-1:0]       pc_part;
  logic [HIST_W-1:0]       idx_src;
  logic [HIST_W-1:0]       idx_full;
  logic [IDX_W-1:0]        idx;
  logic [COUNTER_BITS-1:0] ctr_rd;
  logic [COUNTER_BITS-1:0] ctr_new;
  logic                    pred;
  logic [HIST_W-1:0]       hist_new;
  logic                    hist_we;
  logic                    ctr_we;
  logic                    tbl_we;
  logic [IDX_W-1:0]        tbl_waddr;
  logic [COUNTER_BITS-1:0] tbl_wdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      history_length <= HISTORY_LENGTH_RST;
      pc_shift       <= PC_SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HISTORY_LENGTH: history_length <= cfg_data[LEN_W-1:0];
        CFG_PC_SHIFT:       pc_shift       <= cfg_data[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item <= req;
    end
  end

  always_comb begin
    len_sat = (history_length > LEN_W'(HIST_W)) ? LEN_W'(HIST_W) : history_length;
    for (int i = 0; i < HIST_W; i++) begin
      hmask[i] = (i < int'(len_sat));
    end
  end

  assign tid        = TID_W'(item.thread);
  assign item_ok    = (int'(item.thread) < THREADS) && (item.operation <= OP_BTB_MISS);
  assign hist_cur   = history[tid];
  assign snap       = hist_cur & hmask;
  assign pc_shifted = item.pc >> pc_shift;
  assign pc_part    = pc_shifted[HIST_W-1:0] & hmask;
  // Training uses the snapshot handed back at lookup, not the live history.
  assign idx_src    = (item.operation == OP_UPDATE) ? item.saved_history : snap;
  assign idx_full   = (pc_part ^ idx_src) & IDX_MASK;
  assign idx        = idx_full[IDX_W-1:0];
  assign pred       = ctr_rd[COUNTER_BITS-1];

  always_comb begin
    ctr_new = ctr_rd;
    if (item.outcome_taken) begin
      if (ctr_rd != CTR_MAX) begin
        ctr_new = ctr_rd + COUNTER_BITS'(1);
      end
    end else if (ctr_rd != '0) begin
      ctr_new = ctr_rd - COUNTER_BITS'(1);
    end
  end

  always_comb begin
    hist_new = '0;
    hist_we  = 1'b0;
    ctr_we   = 1'b0;
    unique case (item.operation)
      OP_LOOKUP: begin
        hist_new = {hist_cur[HIST_W-2:0], pred} & hmask;
        hist_we  = 1'b1;
      end
      OP_UNCOND: begin
        hist_new = {hist_cur[HIST_W-2:0], 1'b1} & hmask;
        hist_we  = 1'b1;
      end
      OP_UPDATE: begin
        hist_new = {item.saved_history[HIST_W-2:0], item.outcome_taken} & hmask;
        hist_we  = item.was_squashed;
        ctr_we   = !item.was_squashed;
      end
      OP_SQUASH: begin
        hist_new = item.saved_history & hmask;
        hist_we  = 1'b1;
      end
      OP_BTB_MISS: begin
        hist_new = hist_cur & hmask & ~HIST_W'(1);
        hist_we  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < THREADS; t++) begin
        history[t] <= '0;
      end
    end else if (ctl.commit && item_ok && hist_we) begin
      history[tid] <= hist_new;
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear_step) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  assign tbl_we    = ctl.clear_step || (ctl.commit && item_ok && ctr_we);
  assign tbl_waddr = ctl.clear_step ? clr_addr : idx;
  assign tbl_wdata = ctl.clear_step ? '0 : ctr_new;

  gsp_ram #(
    .WIDTH(COUNTER_BITS),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .re   (ctl.read_table),
    .raddr(idx),
    .rdata(ctr_rd)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp.predict_taken    <= item_ok && (item.operation == OP_LOOKUP) && pred;
      rsp.history_snapshot <= (item_ok && ((item.operation == OP_LOOKUP) ||
                               (item.operation == OP_UNCOND))) ? snap : '0;
    end
  end

  assign sts.out_free   = !rsp_valid || !rsp_stall;
  assign sts.clear_last = (clr_addr == IDX_W'(TABLE_ENTRIES - 1));

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> rsp_valid)
    else $error("committed item did not reach the result register");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(ctl.commit))
    else $error("result appeared without a commit");

  a_pred_only_lookup: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && (item.operation != OP_LOOKUP) |=> !rsp.predict_taken)
    else $error("prediction set for an operation other than lookup");

endmodule

### design/gshare_branch_predictor.sv
// Top level of the gshare branch direction predictor.
//
//   Channel | Handshake               | Payload                          | Notes
//   --------+-------------------------+----------------------------------+----------------------
//   req     | req_valid / req_stall   | req (operation, thread, pc, ...) | one item per request
//   rsp     | rsp_valid / rsp_stall   | rsp (predict_taken, snapshot)    | one item per request
//   cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data              | ready is always high
//
// Each item goes through accept, counter table read, then commit of the
// history, counter write-back and result. The registered read of the table RAM
// followed by its write-back sets these steps.
// After reset a clearing pass writes zero to all TABLE_ENTRIES counters, one per
// cycle, and no item is accepted until the pass ends; config writes are taken.
// A result held by rsp_stall waits in the output register while the next item
// is accepted; that item waits before commit until the register is free.
`timescale 1ns / 1ps
module gshare_branch_predictor #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int COUNTER_BITS  = 2,
  parameter int THREADS       = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  gsp_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output gsp_pkg::rsp_t                   rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gsp_pkg::*;

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  // Configuration registers accept a write in any cycle.
  assign cfg_ready = 1'b1;

  // The controller sequences each item; it never touches payload itself.
  gsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // The datapath holds the histories, counter table and result register.
  gsp_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .COUNTER_BITS (COUNTER_BITS),
    .THREADS      (THREADS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .ctl      (ctl),
    .sts      (sts),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule
